// ===== hdl/rvexu_pkg.sv =====
// Package for the RV32I execute unit: codes, word types and shared constants.
package rvexu_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int MEM_AW    = $clog2(MEM_BYTES);

   typedef logic [MEM_AW-1:0] mem_addr_type;

   typedef enum logic [5:0] {
      CMD_ADD    = 6'd0,
      CMD_SUB    = 6'd1,
      CMD_AND    = 6'd2,
      CMD_OR     = 6'd3,
      CMD_XOR    = 6'd4,
      CMD_SLL    = 6'd5,
      CMD_SRL    = 6'd6,
      CMD_SRA    = 6'd7,
      CMD_SLT    = 6'd8,
      CMD_SLTU   = 6'd9,
      CMD_ADDI   = 6'd10,
      CMD_ANDI   = 6'd11,
      CMD_ORI    = 6'd12,
      CMD_XORI   = 6'd13,
      CMD_SLLI   = 6'd14,
      CMD_SRLI   = 6'd15,
      CMD_SRAI   = 6'd16,
      CMD_SLTI   = 6'd17,
      CMD_SLTIU  = 6'd18,
      CMD_LUI    = 6'd19,
      CMD_AUIPC  = 6'd20,
      CMD_LB     = 6'd21,
      CMD_LH     = 6'd22,
      CMD_LW     = 6'd23,
      CMD_LBU    = 6'd24,
      CMD_LHU    = 6'd25,
      CMD_SB     = 6'd26,
      CMD_SH     = 6'd27,
      CMD_SW     = 6'd28,
      CMD_BEQ    = 6'd29,
      CMD_BNE    = 6'd30,
      CMD_BLT    = 6'd31,
      CMD_BGE    = 6'd32,
      CMD_BLTU   = 6'd33,
      CMD_BGEU   = 6'd34,
      CMD_JAL    = 6'd35,
      CMD_JALR   = 6'd36,
      CMD_ECALL  = 6'd37,
      CMD_EBREAK = 6'd38,
      CMD_FENCE  = 6'd39
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MEM,
      ST_WB
   } state_type;

   typedef struct packed {
      logic [5:0]         cmd;
      logic [4:0]         dest_index;
      logic [4:0]         src1_index;
      logic [4:0]         src2_index;
      logic signed [31:0] immediate;
      logic [31:0]        current_pc;
   } req_type;

   typedef struct packed {
      logic        reg_written;
      logic [4:0]  write_index;
      logic [31:0] write_value;
      logic        pc_changed;
      logic [31:0] next_pc;
      logic        halt;
   } rsp_type;

   // execute result handed from the ALU to the sequencer
   typedef struct packed {
      logic         writes;
      logic         changed;
      logic         halt;
      logic         is_load;
      logic         is_store;
      logic         ld_signed;
      logic [1:0]   mem_last;   // index of the last byte lane of the access
      logic [31:0]  res;
      logic [31:0]  npc;
      mem_addr_type addr;
      logic [31:0]  st_data;
   } alu_out_type;

endpackage

// ===== hdl/rvexu_regfile.sv =====
// 32 x 32 register file: two registered read ports, one write port, cleared by valid bits.
module rvexu_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr1,
   input  logic [4:0]  rd_addr2,
   output logic [31:0] rd_data1,
   output logic [31:0] rd_data2,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   import rvexu_pkg::*;

   logic [31:0] rf_mem_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] valid_in;
   logic [31:0] rd_data1_ff;
   logic [31:0] rd_data2_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read-during-write of the same entry returns the new data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr1) begin
            rd_data1_ff <= wr_data;
         end else begin
            rd_data1_ff <= valid_ff[rd_addr1] ? rf_mem_ff[rd_addr1] : '0;
         end
         if (wr_en && wr_addr == rd_addr2) begin
            rd_data2_ff <= wr_data;
         end else begin
            rd_data2_ff <= valid_ff[rd_addr2] ? rf_mem_ff[rd_addr2] : '0;
         end
      end
   end

   assign rd_data1 = rd_data1_ff;
   assign rd_data2 = rd_data2_ff;

endmodule

// ===== hdl/rvexu_dmem.sv =====
// Byte-wide data memory, single port, registered read data.
module rvexu_dmem (
   input  logic                    clock,
   input  logic                    en,
   input  logic                    we,
   input  rvexu_pkg::mem_addr_type addr,
   input  logic [7:0]              wr_data,
   output logic [7:0]              rd_data
);
   import rvexu_pkg::*;

   logic [7:0] byte_mem_ff [MEM_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            byte_mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= byte_mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rvexu_alu.sv =====
// Integer ALU, branch compare and address generation for one instruction.
module rvexu_alu (
   input  logic [5:0]             cmd,
   input  logic [31:0]            src_a,
   input  logic [31:0]            src_b,
   input  logic [31:0]            imm,
   input  logic [31:0]            pc,
   output rvexu_pkg::alu_out_type result
);
   import rvexu_pkg::*;

   logic [31:0] sum_ab;
   logic [31:0] diff_ab;
   logic [31:0] sum_ai;
   logic [31:0] pc_imm;
   logic [31:0] pc_link;
   logic        lt_s_ab;
   logic        lt_u_ab;
   logic        lt_s_ai;
   logic        lt_u_ai;
   logic        eq_ab;
   logic        taken;

   assign sum_ab  = src_a + src_b;
   assign diff_ab = src_a - src_b;
   assign sum_ai  = src_a + imm;
   assign pc_imm  = pc + imm;
   assign pc_link = pc + 32'd4;
   assign lt_s_ab = $signed(src_a) < $signed(src_b);
   assign lt_u_ab = src_a < src_b;
   assign lt_s_ai = $signed(src_a) < $signed(imm);
   assign lt_u_ai = src_a < imm;
   assign eq_ab   = src_a == src_b;

   always_comb begin
      result         = '0;
      result.npc     = pc;
      result.addr    = sum_ai[MEM_AW-1:0];
      result.st_data = src_b;
      taken          = 1'b0;
      unique case (cmd)
         CMD_ADD:   begin result.writes = 1'b1; result.res = sum_ab; end
         CMD_SUB:   begin result.writes = 1'b1; result.res = diff_ab; end
         CMD_AND:   begin result.writes = 1'b1; result.res = src_a & src_b; end
         CMD_OR:    begin result.writes = 1'b1; result.res = src_a | src_b; end
         CMD_XOR:   begin result.writes = 1'b1; result.res = src_a ^ src_b; end
         CMD_SLL:   begin result.writes = 1'b1; result.res = src_a << src_b[4:0]; end
         CMD_SRL:   begin result.writes = 1'b1; result.res = src_a >> src_b[4:0]; end
         CMD_SRA:   begin
            result.writes = 1'b1;
            result.res    = $unsigned($signed(src_a) >>> src_b[4:0]);
         end
         CMD_SLT:   begin result.writes = 1'b1; result.res = {31'd0, lt_s_ab}; end
         CMD_SLTU:  begin result.writes = 1'b1; result.res = {31'd0, lt_u_ab}; end
         CMD_ADDI:  begin result.writes = 1'b1; result.res = sum_ai; end
         CMD_ANDI:  begin result.writes = 1'b1; result.res = src_a & imm; end
         CMD_ORI:   begin result.writes = 1'b1; result.res = src_a | imm; end
         CMD_XORI:  begin result.writes = 1'b1; result.res = src_a ^ imm; end
         CMD_SLLI:  begin result.writes = 1'b1; result.res = src_a << imm[4:0]; end
         CMD_SRLI:  begin result.writes = 1'b1; result.res = src_a >> imm[4:0]; end
         CMD_SRAI:  begin
            result.writes = 1'b1;
            result.res    = $unsigned($signed(src_a) >>> imm[4:0]);
         end
         CMD_SLTI:  begin result.writes = 1'b1; result.res = {31'd0, lt_s_ai}; end
         CMD_SLTIU: begin result.writes = 1'b1; result.res = {31'd0, lt_u_ai}; end
         CMD_LUI:   begin result.writes = 1'b1; result.res = imm; end
         CMD_AUIPC: begin result.writes = 1'b1; result.res = pc_imm; end
         CMD_LB:    begin
            result.writes = 1'b1; result.is_load = 1'b1;
            result.ld_signed = 1'b1; result.mem_last = 2'd0;
         end
         CMD_LH:    begin
            result.writes = 1'b1; result.is_load = 1'b1;
            result.ld_signed = 1'b1; result.mem_last = 2'd1;
         end
         CMD_LW:    begin
            result.writes = 1'b1; result.is_load = 1'b1; result.mem_last = 2'd3;
         end
         CMD_LBU:   begin
            result.writes = 1'b1; result.is_load = 1'b1; result.mem_last = 2'd0;
         end
         CMD_LHU:   begin
            result.writes = 1'b1; result.is_load = 1'b1; result.mem_last = 2'd1;
         end
         CMD_SB:    begin result.is_store = 1'b1; result.mem_last = 2'd0; end
         CMD_SH:    begin result.is_store = 1'b1; result.mem_last = 2'd1; end
         CMD_SW:    begin result.is_store = 1'b1; result.mem_last = 2'd3; end
         CMD_BEQ:   taken = eq_ab;
         CMD_BNE:   taken = !eq_ab;
         CMD_BLT:   taken = lt_s_ab;
         CMD_BGE:   taken = !lt_s_ab;
         CMD_BLTU:  taken = lt_u_ab;
         CMD_BGEU:  taken = !lt_u_ab;
         CMD_JAL:   begin
            result.writes = 1'b1; result.res = pc_link;
            result.changed = 1'b1; result.npc = pc_imm;
         end
         CMD_JALR:  begin
            result.writes = 1'b1; result.res = pc_link;
            result.changed = 1'b1; result.npc = {sum_ai[31:1], 1'b0};
         end
         CMD_FENCE: begin end
         default:   result.halt = 1'b1;
      endcase
      if (taken) begin
         result.changed = 1'b1;
         result.npc     = pc_imm;
      end
   end

endmodule

// ===== hdl/rv32i_execute_unit.sv =====
// RV32I execute unit top level: sequencer around the register file, ALU and data memory.
//
// One instruction word at a time. A word that neither loads nor stores goes through
// register file read, execute and write back. A store writes its bytes (1, 2 or 4) to
// the data memory one at a time, and a load reads them one at a time and then captures
// the last one, since the data memory has one byte-wide port with registered read data
// and each byte address wraps on its own. The result sits in an output register; write
// back waits until that register is free, and a new word is accepted once the previous
// one has been written back, even while its result still waits to be taken. Data memory
// is not cleared: reading a byte never stored returns whatever it holds.
module rv32i_execute_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rvexu_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rvexu_pkg::rsp_type rsp_word
);
   import rvexu_pkg::*;

   state_type    state_ff, state_in;
   req_type      req_ff, req_in;
   alu_out_type  ex_ff, ex_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [31:0]  load_ff, load_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic         accept;
   logic         out_free;
   logic         rf_wr_en;
   logic [31:0]  rf_rd_data1;
   logic [31:0]  rf_rd_data2;
   logic         dm_en;
   logic         dm_we;
   mem_addr_type dm_addr;
   logic [7:0]   dm_wr_data;
   logic [7:0]   dm_rd_data;
   logic         cap_load;
   logic         rsp_load;
   logic [2:0]   mem_count;
   logic [1:0]   lane_prev;
   alu_out_type  alu_out;
   logic         wb_write;
   logic [31:0]  wb_value;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_count = {1'b0, ex_ff.mem_last};
   assign lane_prev = cnt_ff[1:0] - 2'd1;

   rvexu_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr1 (req_word.src1_index),
      .rd_addr2 (req_word.src2_index),
      .rd_data1 (rf_rd_data1),
      .rd_data2 (rf_rd_data2),
      .wr_en    (rf_wr_en),
      .wr_addr  (req_ff.dest_index),
      .wr_data  (wb_value)
   );

   rvexu_alu u_alu (
      .cmd    (req_ff.cmd),
      .src_a  (rf_rd_data1),
      .src_b  (rf_rd_data2),
      .imm    (req_ff.immediate),
      .pc     (req_ff.current_pc),
      .result (alu_out)
   );

   rvexu_dmem u_dmem (
      .clock   (clock),
      .en      (dm_en),
      .we      (dm_we),
      .addr    (dm_addr),
      .wr_data (dm_wr_data),
      .rd_data (dm_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (alu_out.is_load || alu_out.is_store) ? ST_MEM : ST_WB;
         end
         ST_MEM: begin
            if (ex_ff.is_store && cnt_ff == mem_count) begin
               state_in = ST_WB;
            end else if (ex_ff.is_load && cnt_ff == mem_count + 3'd1) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      dm_en     = 1'b0;
      cap_load  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = !reset;
         ST_READ: begin end
         ST_MEM: begin
            dm_en    = cnt_ff <= mem_count;
            cap_load = ex_ff.is_load && cnt_ff != 3'd0;
         end
         ST_WB: rsp_load = out_free;
         default: begin end
      endcase
   end

   assign dm_we    = dm_en && ex_ff.is_store;
   assign dm_addr  = ex_ff.addr + mem_addr_type'(cnt_ff[1:0]);
   assign wb_write = ex_ff.writes && req_ff.dest_index != 5'd0;
   assign rf_wr_en = rsp_load && wb_write;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: dm_wr_data = ex_ff.st_data[7:0];
         2'd1: dm_wr_data = ex_ff.st_data[15:8];
         2'd2: dm_wr_data = ex_ff.st_data[23:16];
         2'd3: dm_wr_data = ex_ff.st_data[31:24];
      endcase
   end

   // load byte lanes arrive in the cycle after their address
   always_comb begin
      load_in = load_ff;
      if (cap_load) begin
         unique case (lane_prev)
            2'd0: load_in[7:0]   = dm_rd_data;
            2'd1: load_in[15:8]  = dm_rd_data;
            2'd2: load_in[23:16] = dm_rd_data;
            2'd3: load_in[31:24] = dm_rd_data;
         endcase
      end
   end

   always_comb begin
      if (ex_ff.is_load) begin
         unique case (ex_ff.mem_last)
            2'd0: wb_value = {{24{ex_ff.ld_signed && load_ff[7]}}, load_ff[7:0]};
            2'd1: wb_value = {{16{ex_ff.ld_signed && load_ff[15]}}, load_ff[15:0]};
            default: wb_value = load_ff;
         endcase
      end else begin
         wb_value = ex_ff.res;
      end
   end

   always_comb begin
      req_in = accept ? req_word : req_ff;
      ex_in  = (state_ff == ST_READ) ? alu_out : ex_ff;
      cnt_in = (state_ff == ST_MEM) ? cnt_ff + 3'd1 : 3'd0;

      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.reg_written = wb_write;
         rsp_in.write_index = wb_write ? req_ff.dest_index : 5'd0;
         rsp_in.write_value = wb_write ? wb_value : 32'd0;
         rsp_in.pc_changed  = ex_ff.changed;
         rsp_in.next_pc     = ex_ff.npc;
         rsp_in.halt        = ex_ff.halt;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      ex_ff   <= ex_in;
      load_ff <= load_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
